### src/assert_macros.svh
// Assertion helpers for the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define ORT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ORT_ASSERT_ALWAYS(lbl, cond, msg)
`define ORT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/ort_pkg.sv
`timescale 1ns / 1ps
package ort_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PEER_COUNT_DEF  = 32;

    // op codes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RESP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // message kinds
    localparam logic [3:0] K_HELLO        = 4'd0;
    localparam logic [3:0] K_HELLO_ACK    = 4'd1;
    localparam logic [3:0] K_DATA_REQ     = 4'd2;
    localparam logic [3:0] K_DATA_RESP    = 4'd3;
    localparam logic [3:0] K_SUB          = 4'd4;
    localparam logic [3:0] K_UNSUB        = 4'd5;
    localparam logic [3:0] K_LIST_REQ     = 4'd6;
    localparam logic [3:0] K_LIST_RESP    = 4'd7;
    localparam logic [3:0] K_QUERY_REQ    = 4'd8;
    localparam logic [3:0] K_QUERY_RESP   = 4'd9;
    localparam logic [3:0] K_METRICS_REQ  = 4'd10;
    localparam logic [3:0] K_METRICS_RESP = 4'd11;

    // result events
    localparam logic [2:0] EV_SEND    = 3'd0;
    localparam logic [2:0] EV_RESP    = 3'd1;
    localparam logic [2:0] EV_TICK    = 3'd2;
    localparam logic [2:0] EV_RESEND  = 3'd3;
    localparam logic [2:0] EV_TIMEOUT = 3'd4;
    localparam logic [2:0] EV_UNUSED  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PENDING   = 3'd1;
    localparam logic [2:0] ST_NO_ROUTE  = 3'd2;
    localparam logic [2:0] ST_NO_HANDLR = 3'd3;
    localparam logic [2:0] ST_SEND_FAIL = 3'd4;
    localparam logic [2:0] ST_EXHAUSTED = 3'd5;

    // config register indexes
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_LIMIT    = 2'd1;
    localparam logic [1:0] REG_TABLE    = 2'd2;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_APPEND,
        ACT_REMOVE,
        ACT_TOUCH
    } ort_act_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [3:0]  req_kind;
        logic [3:0]  rep_kind;
        logic [31:0] sent;
        logic [7:0]  retries;
    } ort_entry_t;

    typedef struct packed {
        ort_act_t    act;
        logic [15:0] ident;
        logic [3:0]  req_kind;
        logic [3:0]  rep_kind;
        logic [31:0] now;
        logic [31:0] interval;
        logic [7:0]  limit;
    } ort_cmd_t;

    typedef struct packed {
        logic id_hit;
        logic resp_hit;
        logic expired;
        logic exhausted;
    } ort_flags_t;

    function automatic logic is_txn(input logic [3:0] k);
        return (k == K_HELLO) || (k == K_DATA_REQ) || (k == K_SUB) || (k == K_UNSUB)
            || (k == K_LIST_REQ) || (k == K_QUERY_REQ) || (k == K_METRICS_REQ);
    endfunction

    function automatic logic [3:0] reply_of(input logic [3:0] k);
        logic [3:0] r;
        r = K_HELLO;
        unique case (k)
            K_HELLO:                       r = K_HELLO_ACK;
            K_DATA_REQ, K_SUB, K_UNSUB:    r = K_DATA_RESP;
            K_LIST_REQ:                    r = K_LIST_RESP;
            K_QUERY_REQ:                   r = K_QUERY_RESP;
            K_METRICS_REQ:                 r = K_METRICS_RESP;
            default:                       r = K_HELLO;
        endcase
        return r;
    endfunction

    function automatic logic is_reply(input logic [3:0] k);
        return (k == K_HELLO_ACK) || (k == K_DATA_RESP) || (k == K_LIST_RESP)
            || (k == K_QUERY_RESP) || (k == K_METRICS_RESP);
    endfunction

endpackage

### src/ort_cell.sv
`timescale 1ns / 1ps
module ort_cell
    import ort_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int PW       = 5,
    parameter int CW       = 5,
    parameter int IW       = 4
)
(
    input  logic              clk,
    input  ort_cmd_t          cmd,
    input  logic [PW-1:0]     cmd_peer,
    input  logic [IW-1:0]     cmd_pos,
    input  logic [CW-1:0]     count,
    input  ort_entry_t        nb_entry,
    input  logic [PW-1:0]     nb_peer,
    output ort_entry_t        entry,
    output logic [PW-1:0]     peer,
    output ort_flags_t        flags
);

    ort_entry_t    entry_reg;
    logic [PW-1:0] peer_reg;
    logic          live;
    logic          at_pos;
    logic          after_pos;
    logic [31:0]   age;

    assign live      = CW'(CELL_IDX) < count;
    assign at_pos    = IW'(CELL_IDX) == cmd_pos;
    assign after_pos = IW'(CELL_IDX) >= cmd_pos;
    assign age       = cmd.now - entry_reg.sent;

    always_ff @(posedge clk)
    begin
        unique case (cmd.act)
            ACT_APPEND:
            begin
                if (at_pos)
                begin
                    entry_reg.ident    <= cmd.ident;
                    entry_reg.req_kind <= cmd.req_kind;
                    entry_reg.rep_kind <= cmd.rep_kind;
                    entry_reg.sent     <= cmd.now;
                    entry_reg.retries  <= 8'd0;
                    peer_reg           <= cmd_peer;
                end
            end
            ACT_REMOVE:
            begin
                // close the gap: take the right neighbor's entry
                if (after_pos)
                begin
                    entry_reg <= nb_entry;
                    peer_reg  <= nb_peer;
                end
            end
            ACT_TOUCH:
            begin
                if (at_pos)
                begin
                    entry_reg.sent    <= cmd.now;
                    entry_reg.retries <= entry_reg.retries + 8'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign entry           = entry_reg;
    assign peer            = peer_reg;
    assign flags.id_hit    = live && (entry_reg.ident == cmd.ident);
    assign flags.resp_hit  = flags.id_hit && (entry_reg.rep_kind == cmd.rep_kind)
                             && (peer_reg == cmd_peer);
    assign flags.expired   = live && (age >= cmd.interval);
    assign flags.exhausted = entry_reg.retries >= cmd.limit;

endmodule

### src/outstanding_request_tracker.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Beat carries
// in      | in        | in_valid/in_ready  | op, msg_kind, msg_ident, peer_index, flags, now
// out     | out       | out_valid/out_ready| event_res, status, matched, ident, peer, kind, last
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// Send runs its checks in S_SEND; an id allocation probes candidate ids in S_ALLOC
// (at most TABLE_DEPTH+1 probes) and then returns to the send checks. Response is
// handled in S_RESP. Tick walks the cell chain in S_WALK one entry a cycle while the
// output does not stall. Reset clears state, counts, id counter, out_valid and config;
// entry cells hold no reset and are only read below the entry count. Output stalls
// hold the walk at an expired entry; a new input beat is taken once the previous item
// has placed its last result.
`include "assert_macros.svh"
module outstanding_request_tracker
    import ort_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PEER_COUNT  = PEER_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [3:0]                    msg_kind,
    input  logic [15:0]                   msg_ident,
    input  logic [$clog2(PEER_COUNT)-1:0] peer_index,
    input  logic                          dst_present,
    input  logic                          has_callback,
    input  logic                          link_ok,
    input  logic [31:0]                   now,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    event_res,
    output logic [2:0]                    status,
    output logic                          matched,
    output logic [15:0]                   result_ident,
    output logic [$clog2(PEER_COUNT)-1:0] result_peer,
    output logic [3:0]                    request_kind,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int PW   = $clog2(PEER_COUNT);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SEND  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_RESP  = 6'b001000,
        S_WALK  = 6'b010000,
        S_NOP   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;

    // config
    logic [31:0]   interval_reg;
    logic [7:0]    limit_reg;
    logic [4:0]    table_lim_reg;

    // control
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   next_id_reg, next_id_next;
    logic [31:0]   timeouts_reg, timeouts_next;
    logic [15:0]   cand_reg, cand_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic          any_reg, any_next;

    // latched item
    logic [3:0]    it_kind_reg;
    logic [15:0]   it_ident_reg, it_ident_next;
    logic [PW-1:0] it_peer_reg;
    logic          it_dst_reg;
    logic          it_cb_reg;
    logic          it_link_reg;
    logic [31:0]   it_now_reg;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    ev_reg, ev_next;
    logic [2:0]    st_reg, st_next;
    logic          m_reg, m_next;
    logic [15:0]   rid_reg, rid_next;
    logic [PW-1:0] rpeer_reg, rpeer_next;
    logic [3:0]    rkind_reg, rkind_next;
    logic          last_reg, last_next;

    // cell chain
    ort_cmd_t      cmd;
    logic [IW-1:0] cmd_pos;
    ort_entry_t    ent   [TABLE_DEPTH];
    logic [PW-1:0] epeer [TABLE_DEPTH];
    ort_flags_t    flg   [TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            ort_entry_t    nb_e;
            logic [PW-1:0] nb_p;
            if (g == TABLE_DEPTH - 1)
            begin : g_end
                assign nb_e = ent[g];
                assign nb_p = epeer[g];
            end
            else
            begin : g_mid
                assign nb_e = ent[g+1];
                assign nb_p = epeer[g+1];
            end
            ort_cell #(
                .CELL_IDX (g),
                .PW       (PW),
                .CW       (CW),
                .IW       (IW)
            ) u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .cmd_peer (it_peer_reg),
                .cmd_pos  (cmd_pos),
                .count    (count_reg),
                .nb_entry (nb_e),
                .nb_peer  (nb_p),
                .entry    (ent[g]),
                .peer     (epeer[g]),
                .flags    (flg[g])
            );
        end
    endgenerate

    // match summary across the chain
    logic          id_any;
    logic          resp_any;
    logic [IW-1:0] resp_idx;

    always_comb
    begin
        id_any   = 1'b0;
        resp_any = 1'b0;
        resp_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (flg[i].id_hit)
                id_any = 1'b1;
            if (flg[i].resp_hit)
            begin
                resp_any = 1'b1;
                resp_idx = IW'(i);
            end
        end
    end

    logic          out_free;
    logic          txn;
    logic [3:0]    reply;
    logic [CMPW-1:0] lim_sat;
    logic          full;
    logic          need_alloc;
    logic [2:0]    send_st;
    logic [IW-1:0] walk_idx;
    logic [15:0]   cand_inc;

    assign out_free   = !out_valid_reg || out_ready;
    assign txn        = is_txn(it_kind_reg);
    assign reply      = reply_of(it_kind_reg);
    assign lim_sat    = (CMPW'(table_lim_reg) > CMPW'(TABLE_DEPTH)) ? CMPW'(TABLE_DEPTH)
                                                                   : CMPW'(table_lim_reg);
    assign full       = CMPW'(count_reg) >= lim_sat;
    assign need_alloc = (table_lim_reg != 5'd0) && txn && it_dst_reg
                        && (it_ident_reg == 16'd0);
    assign walk_idx   = walk_reg[IW-1:0];
    assign cand_inc   = (cand_reg == 16'hFFFF) ? 16'd1 : cand_reg + 16'd1;

    always_comb
    begin
        send_st = ST_OK;
        priority if (table_lim_reg == 5'd0)
            send_st = ST_PENDING;
        else if (txn)
        begin
            priority if (!it_dst_reg)
                send_st = ST_NO_ROUTE;
            else if (id_any || full)
                send_st = ST_PENDING;
            else
                send_st = ST_OK;
        end
        else if (it_cb_reg)
            send_st = ST_NO_HANDLR;
        else
            send_st = ST_OK;
        if (send_st == ST_OK && !it_link_reg)
            send_st = ST_SEND_FAIL;
    end

    // chain command
    always_comb
    begin
        cmd.act      = ACT_HOLD;
        cmd.ident    = state_reg == S_ALLOC ? cand_reg : it_ident_reg;
        cmd.req_kind = it_kind_reg;
        cmd.rep_kind = state_reg == S_RESP ? it_kind_reg : reply;
        cmd.now      = it_now_reg;
        cmd.interval = interval_reg;
        cmd.limit    = limit_reg;
        cmd_pos      = count_reg[IW-1:0];
        unique case (state_reg)
            S_SEND:
            begin
                if (out_free && !need_alloc && send_st == ST_OK && txn)
                    cmd.act = ACT_APPEND;
            end
            S_RESP:
            begin
                cmd_pos = resp_idx;
                if (out_free && is_reply(it_kind_reg) && resp_any)
                    cmd.act = ACT_REMOVE;
            end
            S_WALK:
            begin
                cmd_pos = walk_idx;
                if (walk_reg < count_reg && flg[walk_idx].expired && out_free)
                    cmd.act = flg[walk_idx].exhausted ? ACT_REMOVE : ACT_TOUCH;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        timeouts_next  = timeouts_reg;
        cand_next      = cand_reg;
        walk_next      = walk_reg;
        any_next       = any_reg;
        it_ident_next  = it_ident_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ev_next        = ev_reg;
        st_next        = st_reg;
        m_next         = m_reg;
        rid_next       = rid_reg;
        rpeer_next     = rpeer_reg;
        rkind_next     = rkind_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    it_ident_next = msg_ident;
                    cand_next     = next_id_reg;
                    walk_next     = '0;
                    any_next      = 1'b0;
                    unique case (op)
                        OP_SEND: state_next = S_SEND;
                        OP_RESP: state_next = S_RESP;
                        OP_TICK: state_next = S_WALK;
                        default: state_next = S_NOP;
                    endcase
                end
            end
            S_SEND:
            begin
                if (need_alloc)
                    state_next = S_ALLOC;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_SEND;
                    st_next        = send_st;
                    m_next         = 1'b0;
                    rid_next       = it_ident_reg;
                    rpeer_next     = it_peer_reg;
                    rkind_next     = it_kind_reg;
                    last_next      = 1'b1;
                    if (cmd.act == ACT_APPEND)
                        count_next = count_reg + CW'(1);
                    state_next     = S_IDLE;
                end
            end
            S_ALLOC:
            begin
                // probe one candidate id per cycle against every live cell
                if (!id_any)
                begin
                    it_ident_next = cand_reg;
                    next_id_next  = cand_inc;
                    state_next    = S_SEND;
                end
                else
                    cand_next = cand_inc;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_RESP;
                    st_next        = ST_OK;
                    m_next         = cmd.act == ACT_REMOVE;
                    rid_next       = it_ident_reg;
                    rpeer_next     = it_peer_reg;
                    rkind_next     = cmd.act == ACT_REMOVE ? ent[resp_idx].req_kind : 4'd0;
                    last_next      = 1'b1;
                    if (cmd.act == ACT_REMOVE)
                        count_next = count_reg - CW'(1);
                    state_next     = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (walk_reg >= count_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        ev_next        = EV_TICK;
                        st_next        = any_reg ? ST_EXHAUSTED : ST_OK;
                        m_next         = 1'b0;
                        rid_next       = 16'd0;
                        rpeer_next     = '0;
                        rkind_next     = 4'd0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (!flg[walk_idx].expired)
                    walk_next = walk_reg + CW'(1);
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    m_next         = 1'b0;
                    rid_next       = ent[walk_idx].ident;
                    rpeer_next     = epeer[walk_idx];
                    rkind_next     = ent[walk_idx].req_kind;
                    last_next      = 1'b0;
                    if (flg[walk_idx].exhausted)
                    begin
                        // removed: the next entry slides into this slot
                        ev_next       = EV_TIMEOUT;
                        st_next       = ST_EXHAUSTED;
                        count_next    = count_reg - CW'(1);
                        timeouts_next = timeouts_reg + 32'd1;
                        any_next      = 1'b1;
                    end
                    else
                    begin
                        ev_next   = EV_RESEND;
                        st_next   = ST_OK;
                        walk_next = walk_reg + CW'(1);
                    end
                end
            end
            S_NOP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_UNUSED;
                    st_next        = ST_OK;
                    m_next         = 1'b0;
                    rid_next       = 16'd0;
                    rpeer_next     = '0;
                    rkind_next     = 4'd0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            interval_reg  <= 32'd1000;
            limit_reg     <= 8'd3;
            table_lim_reg <= 5'd16;
            count_reg     <= '0;
            next_id_reg   <= 16'd1;
            timeouts_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            timeouts_reg  <= timeouts_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_INTERVAL: interval_reg  <= cfg_data;
                    REG_LIMIT:    limit_reg     <= cfg_data[7:0];
                    REG_TABLE:    table_lim_reg <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        walk_reg     <= walk_next;
        any_reg      <= any_next;
        it_ident_reg <= it_ident_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            it_kind_reg <= msg_kind;
            it_peer_reg <= peer_index;
            it_dst_reg  <= dst_present;
            it_cb_reg   <= has_callback;
            it_link_reg <= link_ok;
            it_now_reg  <= now;
        end
        ev_reg    <= ev_next;
        st_reg    <= st_next;
        m_reg     <= m_next;
        rid_reg   <= rid_next;
        rpeer_reg <= rpeer_next;
        rkind_reg <= rkind_next;
        last_reg  <= last_next;
    end

    assign in_ready     = state_reg == S_IDLE;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign event_res    = ev_reg;
    assign status       = st_reg;
    assign matched      = m_reg;
    assign result_ident = rid_reg;
    assign result_peer  = rpeer_reg;
    assign request_kind = rkind_reg;
    assign last         = last_reg;

    `ORT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_DEPTH),
        "entry count over depth")
    `ORT_ASSERT_ALWAYS(a_walk_bound, (state_reg != S_WALK) || (walk_reg <= count_reg),
        "walk past count")
    `ORT_ASSERT_NEXT(a_count_step, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1))
        || (count_reg + CW'(1) == $past(count_reg)), "count jumped")

endmodule
